@@ rtl/afk_pkg.sv @@
package afk_pkg;

  localparam int AngW = 16;
  localparam int LenW = 16;
  localparam int OutW = 20;
  localparam int ZW = 34;
  localparam int CW = 33;
  localparam int AtanEntries = 24;
  localparam int DefStages = 16;
  localparam logic signed [CW-1:0] InvGain = 33'sd652032874;
  localparam int OutLimit = 262144;

  localparam logic [1:0] RegBase = 2'd0;
  localparam logic [1:0] RegLink1 = 2'd1;
  localparam logic [1:0] RegLink2 = 2'd2;
  localparam logic [1:0] RegTool = 2'd3;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_at(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    begin
      unique case (i)
        5'd0: v = 34'sd536870912;
        5'd1: v = 34'sd316933406;
        5'd2: v = 34'sd167458907;
        5'd3: v = 34'sd85004756;
        5'd4: v = 34'sd42667331;
        5'd5: v = 34'sd21354465;
        5'd6: v = 34'sd10679838;
        5'd7: v = 34'sd5340245;
        5'd8: v = 34'sd2670163;
        5'd9: v = 34'sd1335087;
        5'd10: v = 34'sd667544;
        5'd11: v = 34'sd333772;
        5'd12: v = 34'sd166886;
        5'd13: v = 34'sd83443;
        5'd14: v = 34'sd41722;
        5'd15: v = 34'sd20861;
        5'd16: v = 34'sd10430;
        5'd17: v = 34'sd5215;
        5'd18: v = 34'sd2608;
        5'd19: v = 34'sd1304;
        5'd20: v = 34'sd652;
        5'd21: v = 34'sd326;
        5'd22: v = 34'sd163;
        5'd23: v = 34'sd81;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

@@ rtl/afk_cordic_cell.sv @@
module afk_cordic_cell import afk_pkg::*; #(
  parameter int Index = 0
) (
  input  logic    clk,
  input  logic    en,
  input  cordic_t din,
  output cordic_t dout
);

  cordic_t nxt;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  always_comb begin
    dx = din.y >>> Index;
    dy = din.x >>> Index;
    if (din.z >= 0) begin
      nxt.x = din.x - dx;
      nxt.y = din.y + dy;
      nxt.z = din.z - atan_at(5'(Index));
    end else begin
      nxt.x = din.x + dx;
      nxt.y = din.y - dy;
      nxt.z = din.z + atan_at(5'(Index));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

@@ rtl/afk_sincos.sv @@
module afk_sincos import afk_pkg::*; #(
  parameter int Stages = DefStages
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [AngW-1:0]       angle,
  output logic signed [CW-1:0]  cos_q30,
  output logic signed [CW-1:0]  sin_q30
);

  localparam int Used = (Stages < AtanEntries) ? Stages : AtanEntries;

  cordic_t chain [Used+1];
  logic [Used:0] flip;
  logic          fl;
  logic [AngW-1:0] a;

  // fold the half turn around pi onto the other side
  always_comb begin
    fl = angle[AngW-1] ^ angle[AngW-2];
    a = fl ? (angle ^ {1'b1, {(AngW-1){1'b0}}}) : angle;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0].x <= InvGain;
      chain[0].y <= '0;
      chain[0].z <= {{(ZW-32){a[AngW-1]}}, a, 16'h0000};
      flip <= {flip[Used-1:0], fl};
    end
  end

  for (genvar i = 0; i < Used; i++) begin : g_cell
    afk_cordic_cell #(.Index(i)) u_cell (
      .clk(clk), .en(en), .din(chain[i]), .dout(chain[i+1])
    );
  end

  assign cos_q30 = flip[Used] ? -chain[Used].x : chain[Used].x;
  assign sin_q30 = flip[Used] ? -chain[Used].y : chain[Used].y;

endmodule

@@ rtl/arm_forward_kinematics_4dof.sv @@
// Four-joint arm forward kinematics. One angle set is taken every cycle
// while the output is free; the result passes through the angle-sum and
// CORDIC input registers, the cell chain, then the product, sum, rounding,
// reach-product and output stages. The pipeline moves as one: it advances
// whenever the output register is empty or being taken. Link lengths must
// be written only while no transfer is in flight.
module arm_forward_kinematics_4dof import afk_pkg::*; #(
  parameter int CORDIC_STAGES = DefStages
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [AngW-1:0] waist_angle,
  input  logic signed [AngW-1:0] shoulder_angle,
  input  logic signed [AngW-1:0] elbow_angle,
  input  logic signed [AngW-1:0] wrist_angle,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [OutW-1:0] pos_x,
  output logic signed [OutW-1:0] pos_y,
  output logic signed [OutW-1:0] pos_z,
  input  logic [2:0]             cfg_index,
  input  logic [LenW-1:0]        cfg_data
);

  localparam int Used = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
  localparam int Lat = Used + 7;

  logic en;
  logic [Lat-2:0] vld;
  logic [LenW-1:0] l1, l2, l3, l4;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1 <= 16'd1232;
      l2 <= 16'd2080;
      l3 <= 16'd1984;
      l4 <= 16'd2016;
    end else if (cfg_we && !cfg_index[2]) begin
      unique case (cfg_index[1:0])
        RegBase:  l1 <= cfg_data;
        RegLink1: l2 <= cfg_data;
        RegLink2: l3 <= cfg_data;
        RegTool:  l4 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // stage 0: cumulative angles
  logic [AngW-1:0] t1, t2, a23, a234;
  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= waist_angle;
      t2 <= shoulder_angle;
      a23 <= shoulder_angle + elbow_angle;
      a234 <= shoulder_angle + elbow_angle + wrist_angle;
    end
  end

  logic signed [CW-1:0] c1, s1, c2, s2, c3, s3, c4, s4;
  afk_sincos #(.Stages(CORDIC_STAGES)) u_sc1 (.clk(clk), .en(en), .angle(t1),
    .cos_q30(c1), .sin_q30(s1));
  afk_sincos #(.Stages(CORDIC_STAGES)) u_sc2 (.clk(clk), .en(en), .angle(t2),
    .cos_q30(c2), .sin_q30(s2));
  afk_sincos #(.Stages(CORDIC_STAGES)) u_sc3 (.clk(clk), .en(en), .angle(a23),
    .cos_q30(c3), .sin_q30(s3));
  afk_sincos #(.Stages(CORDIC_STAGES)) u_sc4 (.clk(clk), .en(en), .angle(a234),
    .cos_q30(c4), .sin_q30(s4));

  // products of lengths and trig values
  logic signed [49:0] pr2, pr3, pr4, pz2, pz3, pz4;
  logic signed [CW-1:0] c1d, s1d, c1e, s1e, c1f, s1f;
  always_ff @(posedge clk) begin
    if (en) begin
      pr2 <= $signed({1'b0, l2}) * c2;
      pr3 <= $signed({1'b0, l3}) * c3;
      pr4 <= $signed({1'b0, l4}) * c4;
      pz2 <= $signed({1'b0, l2}) * s2;
      pz3 <= $signed({1'b0, l3}) * s3;
      pz4 <= $signed({1'b0, l4}) * s4;
      c1d <= c1; s1d <= s1;
      c1e <= c1d; s1e <= s1d;
      c1f <= c1e; s1f <= s1e;
    end
  end

  logic signed [52:0] rsum, zsum;
  always_ff @(posedge clk) begin
    if (en) begin
      rsum <= 53'(pr2) + 53'(pr3) + 53'(pr4);
      zsum <= $signed({7'd0, l1, 30'd0}) + 53'(pz2) + 53'(pz3) + 53'(pz4);
    end
  end

  // round the reach to Q12, z to whole units
  logic signed [34:0] rq;
  logic signed [22:0] zr;
  logic signed [52:0] rs_r, zs_r;
  assign rs_r = rsum + 53'sd131072;
  assign zs_r = zsum + 53'sd536870912;
  always_ff @(posedge clk) begin
    if (en) begin
      rq <= 35'(rs_r >>> 18);
      zr <= 23'(zs_r >>> 30);
    end
  end

  logic signed [67:0] px, py;
  logic signed [22:0] zr2;
  always_ff @(posedge clk) begin
    if (en) begin
      px <= rq * c1f;
      py <= rq * s1f;
      zr2 <= zr;
    end
  end

  function automatic logic signed [OutW-1:0] sat(input logic signed [25:0] v);
    logic signed [OutW-1:0] r;
    begin
      if (v > OutLimit) r = OutW'(OutLimit);
      else if (v < -OutLimit) r = OutW'(-OutLimit);
      else r = v[OutW-1:0];
      return r;
    end
  endfunction

  logic signed [67:0] pxr, pyr;
  assign pxr = (px + (68'sd1 <<< 41)) >>> 42;
  assign pyr = (py + (68'sd1 <<< 41)) >>> 42;

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x <= sat(pxr[25:0]);
      pos_y <= sat(pyr[25:0]);
      pos_z <= sat(26'(zr2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[Lat-3:0], in_valid};
      out_valid <= vld[Lat-2];
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_z))
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("ready mismatch");

endmodule
